### design/tpbp_pkg.sv
// ----------------------------------------------------------------------------
// tpbp_pkg
// Shared types and constants of the turtle plotter: board geometry, command
// codes, headings and the control/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package tpbp_pkg;

  // Board geometry
  localparam int BOARD_SIZE = 64;
  localparam int ROW_AW     = (BOARD_SIZE > 1) ? $clog2(BOARD_SIZE) : 1;

  // Payload widths
  localparam int CMD_W   = 3;
  localparam int STEPS_W = 8;
  localparam int POS_W   = 6;
  localparam int HEAD_W  = 2;
  localparam int BITS_W  = 64;

  typedef logic [BOARD_SIZE-1:0] row_t;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PEN_UP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MOVE     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

  // Headings
  localparam logic [HEAD_W-1:0] HEAD_RIGHT = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_DOWN  = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_LEFT  = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_UP    = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;   // latch request fields, clear step result
    logic pen_up;
    logic pen_dn;
    logic turn_r;
    logic turn_l;
    logic step;      // advance pen, count down, read landing row if pen down
    logic rd_sel;    // read the selected row
    logic wr_mark;   // write back landing row with the pen cell set
    logic set_edge;
    logic cap_row;   // capture read data as row result
    logic load_out;  // load the output register
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             cnt_zero;
    logic             step_ok;
    logic             pen;
  } stat_t;

endpackage

### design/tpbp_in_if.sv
// ----------------------------------------------------------------------------
// tpbp_in_if
// Request channel of the turtle plotter: valid/ready plus command fields.
// ----------------------------------------------------------------------------
interface tpbp_in_if
  import tpbp_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [STEPS_W-1:0] steps;
  logic [POS_W-1:0]   row_select;

  modport source (output valid, output cmd, output steps, output row_select,
                  input ready);
  modport sink   (input valid, input cmd, input steps, input row_select,
                  output ready);
endinterface

### design/tpbp_out_if.sv
// ----------------------------------------------------------------------------
// tpbp_out_if
// Result channel of the turtle plotter: valid/ready plus result fields.
// ----------------------------------------------------------------------------
interface tpbp_out_if
  import tpbp_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BITS_W-1:0] row_bits;
  logic [POS_W-1:0]  pen_col;
  logic [POS_W-1:0]  pen_row;
  logic [HEAD_W-1:0] heading_now;
  logic              edge_hit;

  modport source (output valid, output row_bits, output pen_col, output pen_row,
                  output heading_now, output edge_hit, input ready);
  modport sink   (input valid, input row_bits, input pen_col, input pen_row,
                  input heading_now, input edge_hit, output ready);
endinterface

### design/turtle_pen_bitmap_plotter_unit.sv
// ----------------------------------------------------------------------------
// turtle_pen_bitmap_plotter_unit
// Turtle plotter over a 64 x 64 one-bit board: pen up/down, turns, moves
// that mark landing cells, and row readout.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request (cmd, steps, row_select); out_ch returns exactly
//   one result per request (row_bits, pen_col, pen_row, heading_now, edge_hit).
//   Requests are taken one at a time: in_ch.ready is high only while the
//   sequencer is idle. Pen up/down, turns and unused codes act when the
//   request is decoded; a row read makes one registered memory read; a move
//   takes its steps one by one, and with the pen down each step is a
//   read-modify-write of one board row.
//   A move that would step off the board stops at the edge and sets edge_hit.
//   The output register lets the next request be accepted while a result
//   waits; if out_ch stays stalled, the sequencer holds the following result
//   until the register frees. Reset (rst, synchronous) clears the pen state
//   and the per-row valid bits, so the board reads as blank at once; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module turtle_pen_bitmap_plotter_unit
  import tpbp_pkg::*;
(
  input logic clk,
  input logic rst,
  tpbp_in_if.sink    in_ch,
  tpbp_out_if.source out_ch
);

  ctl_t  ctl;
  stat_t stat;

  tpbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  tpbp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (in_ch.cmd),
    .steps       (in_ch.steps),
    .row_select  (in_ch.row_select),
    .ctl         (ctl),
    .stat        (stat),
    .row_bits    (out_ch.row_bits),
    .pen_col     (out_ch.pen_col),
    .pen_row     (out_ch.pen_row),
    .heading_now (out_ch.heading_now),
    .edge_hit    (out_ch.edge_hit)
  );

endmodule

### design/tpbp_datapath.sv
// ----------------------------------------------------------------------------
// tpbp_datapath
// Pen state, board row memory with per-row valid bits, step logic, and the
// output register.
// ----------------------------------------------------------------------------
module tpbp_datapath
  import tpbp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [STEPS_W-1:0] steps,
  input  logic [POS_W-1:0]   row_select,
  input  ctl_t               ctl,
  output stat_t              stat,
  output logic [BITS_W-1:0]  row_bits,
  output logic [POS_W-1:0]   pen_col,
  output logic [POS_W-1:0]   pen_row,
  output logic [HEAD_W-1:0]  heading_now,
  output logic               edge_hit
);

  // Latched request
  logic [CMD_W-1:0]   op;
  logic [STEPS_W-1:0] cnt;
  logic [POS_W-1:0]   sel;

  // Pen state
  logic [POS_W-1:0]  col_pos;
  logic [POS_W-1:0]  row_pos;
  logic [HEAD_W-1:0] heading;
  logic              pen_down;

  // Per-request result
  logic              edge_flag;
  logic [BITS_W-1:0] row_res;

  // Board memory
  row_t             board [BOARD_SIZE];
  logic [BOARD_SIZE-1:0] row_vld;
  row_t             rd_data;
  logic             rd_ok;

  logic [POS_W-1:0]  col_next;
  logic [POS_W-1:0]  row_next;
  logic              step_ok;
  logic [ROW_AW-1:0] rd_addr;
  logic              rd_en;
  logic              sel_in_range;
  row_t              rd_eff;
  row_t              wr_data;

  // Next pen position and edge check
  always_comb begin
    col_next = col_pos;
    row_next = row_pos;
    step_ok  = 1'b0;
    case (heading)
      HEAD_RIGHT: begin
        step_ok  = (32'(col_pos) != BOARD_SIZE - 1);
        col_next = col_pos + POS_W'(1);
      end
      HEAD_DOWN: begin
        step_ok  = (32'(row_pos) != BOARD_SIZE - 1);
        row_next = row_pos + POS_W'(1);
      end
      HEAD_LEFT: begin
        step_ok  = (col_pos != '0);
        col_next = col_pos - POS_W'(1);
      end
      HEAD_UP: begin
        step_ok  = (row_pos != '0);
        row_next = row_pos - POS_W'(1);
      end
      default: begin
        step_ok = 1'b0;
      end
    endcase
  end

  assign stat.op       = op;
  assign stat.cnt_zero = (cnt == '0);
  assign stat.step_ok  = step_ok;
  assign stat.pen      = pen_down;

  // Read address: landing row on a pen-down step, else the selected row
  assign sel_in_range = (32'(sel) < BOARD_SIZE);
  assign rd_addr = ctl.rd_sel ? sel[ROW_AW-1:0] : row_next[ROW_AW-1:0];
  assign rd_en   = ctl.rd_sel || (ctl.step && pen_down);

  // Unwritten rows read as clear
  assign rd_eff  = rd_ok ? rd_data : '0;
  assign wr_data = rd_eff | (row_t'(1) << col_pos[ROW_AW-1:0]);

  // Memory read and write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= board[rd_addr];
    end
    if (ctl.wr_mark) begin
      board[row_pos[ROW_AW-1:0]] <= wr_data;
    end
  end

  // Row valid bits and read qualifier
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_ok <= row_vld[rd_addr] && (!ctl.rd_sel || sel_in_range);
      end
      if (ctl.wr_mark) begin
        row_vld[row_pos[ROW_AW-1:0]] <= 1'b1;
      end
    end
  end

  // Pen state
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      heading  <= HEAD_RIGHT;
      pen_down <= 1'b0;
    end else begin
      if (ctl.pen_up) pen_down <= 1'b0;
      if (ctl.pen_dn) pen_down <= 1'b1;
      if (ctl.turn_r) heading <= heading + HEAD_W'(1);
      if (ctl.turn_l) heading <= heading - HEAD_W'(1);
      if (ctl.step) begin
        col_pos <= col_next;
        row_pos <= row_next;
      end
    end
  end

  // Request latch, step count and per-request results
  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      op        <= cmd;
      cnt       <= steps;
      sel       <= row_select;
      edge_flag <= 1'b0;
      row_res   <= '0;
    end else begin
      if (ctl.step)     cnt       <= cnt - STEPS_W'(1);
      if (ctl.set_edge) edge_flag <= 1'b1;
      if (ctl.cap_row)  row_res   <= BITS_W'(rd_eff);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      row_bits    <= row_res;
      pen_col     <= col_pos;
      pen_row     <= row_pos;
      heading_now <= heading;
      edge_hit    <= edge_flag;
    end
  end

endmodule

### design/tpbp_ctrl.sv
// ----------------------------------------------------------------------------
// tpbp_ctrl
// Sequencer of the turtle plotter: takes one request, runs its steps through
// the datapath and hands the result to the output register.
// ----------------------------------------------------------------------------
module tpbp_ctrl
  import tpbp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctl_t  ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_MWR  = 3'd3;
  localparam logic [2:0] S_RDW  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_FIN;
        case (stat.op)
          CMD_PEN_UP:   ctl.pen_up = 1'b1;
          CMD_PEN_DOWN: ctl.pen_dn = 1'b1;
          CMD_RIGHT:    ctl.turn_r = 1'b1;
          CMD_LEFT:     ctl.turn_l = 1'b1;
          CMD_MOVE:     state_next = S_STEP;
          CMD_READ: begin
            ctl.rd_sel = 1'b1;
            state_next = S_RDW;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_STEP: begin
        if (stat.cnt_zero) begin
          state_next = S_FIN;
        end else if (!stat.step_ok) begin
          ctl.set_edge = 1'b1;
          state_next   = S_FIN;
        end else begin
          ctl.step   = 1'b1;
          state_next = stat.pen ? S_MWR : S_STEP;
        end
      end
      S_MWR: begin
        ctl.wr_mark = 1'b1;
        state_next  = S_STEP;
      end
      S_RDW: begin
        ctl.cap_row = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  // A finished result waits while the output register is still taken
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && out_valid && !out_ready) |=> (state == S_FIN))
    else $error("result left FIN while output blocked");

  // An accepted request is decoded next
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted request not decoded");

  // A row write-back follows a pen-down step
  a_mwr_after_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_MWR) |-> ($past(state) == S_STEP && $past(stat.pen)))
    else $error("row write without a pen-down step");

  // A result only appears out of FIN
  a_valid_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("output valid raised outside FIN");
`endif

endmodule
